// ----- src/rk4_harmonic_oscillator_step_defines.svh -----
// Assertion macros for the oscillator step controller.
`ifndef RK4_HARMONIC_OSCILLATOR_STEP_DEFINES_SVH
`define RK4_HARMONIC_OSCILLATOR_STEP_DEFINES_SVH
`ifndef SYNTH
`define RK4_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
	else $error("rk4 assertion failed");
`define RK4_ASSERT_NEVER(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
	else $error("rk4 forbidden condition");
`else
`define RK4_ASSERT(lbl, clk, rst_n, prop)
`define RK4_ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

// ----- src/rk4_pkg.sv -----
// Shared types and constants of the oscillator step block.
package rk4_pkg;

	localparam int DATA_W = 48;
	localparam int GAIN_W = 32;
	localparam int CNT_W = 32;
	localparam int ADDR_W = 5;
	localparam int PDATA_W = 64;
	localparam int DIV_STEPS = 7;

	typedef logic [1:0] reg_idx_t;
	localparam reg_idx_t REG_STEP_GAIN = 2'd0;
	localparam reg_idx_t REG_START_POS = 2'd1;
	localparam reg_idx_t REG_START_VEL = 2'd2;

	typedef logic [1:0] stage_t;
	localparam stage_t ST_K1 = 2'd0;
	localparam stage_t ST_K2 = 2'd1;
	localparam stage_t ST_K3 = 2'd2;
	localparam stage_t ST_K4 = 2'd3;

	typedef struct packed {
		logic   start;
		logic   restart;
		logic   mul_hi;
		logic   mul_lo;
		logic   prod;
		logic   upd;
		logic   div_init;
		logic   div_step;
		logic   commit;
		stage_t stage;
		stage_t upd_stage;
	} rk4_cmd_t;

endpackage

// ----- src/rk4_regs.sv -----
// Configuration register file with its APB-style access port.
module rk4_regs #(
	parameter int FRAC_BITS = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [rk4_pkg::ADDR_W-1:0]    paddr,
	input  logic [rk4_pkg::PDATA_W-1:0]   pwdata,
	output logic [rk4_pkg::PDATA_W-1:0]   prdata,
	output logic                          pready,
	output logic [rk4_pkg::GAIN_W-1:0]    step_gain,
	output logic signed [rk4_pkg::DATA_W-1:0] start_position,
	output logic signed [rk4_pkg::DATA_W-1:0] start_velocity
);
	import rk4_pkg::*;

	logic [GAIN_W-1:0]        step_gain_q;
	logic signed [DATA_W-1:0] start_position_q;
	logic signed [DATA_W-1:0] start_velocity_q;
	reg_idx_t                 reg_idx;
	logic                     wr_en;

	assign reg_idx = paddr[ADDR_W-1:ADDR_W-2];
	assign pready = 1'b1;
	assign wr_en = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_gain_q <= GAIN_W'(78496111);
			start_position_q <= DATA_W'(1) << FRAC_BITS;
			start_velocity_q <= '0;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_STEP_GAIN: step_gain_q <= pwdata[GAIN_W-1:0];
				REG_START_POS: start_position_q <= pwdata[DATA_W-1:0];
				REG_START_VEL: start_velocity_q <= pwdata[DATA_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_STEP_GAIN: prdata = PDATA_W'(step_gain_q);
			REG_START_POS: prdata = PDATA_W'(start_position_q);
			REG_START_VEL: prdata = PDATA_W'(start_velocity_q);
			default:       prdata = '0;
		endcase
	end

	assign step_gain = step_gain_q;
	assign start_position = start_position_q;
	assign start_velocity = start_velocity_q;

endmodule

// ----- src/rk4_dp.sv -----
// Datapath: state, shared gain multiplier, stage sums, divide by six and result register.
module rk4_dp #(
	parameter int FRAC_BITS = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  rk4_pkg::rk4_cmd_t                 cmd,
	input  logic [rk4_pkg::GAIN_W-1:0]        step_gain,
	input  logic signed [rk4_pkg::DATA_W-1:0] start_position,
	input  logic signed [rk4_pkg::DATA_W-1:0] start_velocity,
	output logic signed [rk4_pkg::DATA_W-1:0] position,
	output logic signed [rk4_pkg::DATA_W-1:0] scaled_velocity,
	output logic [rk4_pkg::CNT_W-1:0]         step_index
);
	import rk4_pkg::*;

	localparam int WIDE_W = DATA_W + 5;
	localparam int MUL_W = DATA_W + 17;
	localparam int PROD_W = DATA_W + 33;
	localparam int ACC_W = DATA_W + 3;
	localparam int DIV_W = 8 * DIV_STEPS;
	localparam logic signed [DATA_W-1:0] DATA_MAX = {1'b0, {(DATA_W-1){1'b1}}};
	localparam logic signed [DATA_W-1:0] DATA_MIN = {1'b1, {(DATA_W-1){1'b0}}};
	localparam logic [ACC_W:0] DIV_BIAS = (ACC_W + 1)'(3) << (ACC_W - 2);
	localparam logic [WIDE_W-1:0] DIV_OFF = WIDE_W'(1) << (ACC_W - 2);

	function automatic logic signed [DATA_W-1:0] sat48(input logic signed [WIDE_W-1:0] a);
		logic signed [DATA_W-1:0] r;
		if (!a[WIDE_W-1] && a[WIDE_W-2:DATA_W-1] != '0) begin
			r = DATA_MAX;
		end else if (a[WIDE_W-1] && a[WIDE_W-2:DATA_W-1] != '1) begin
			r = DATA_MIN;
		end else begin
			r = a[DATA_W-1:0];
		end
		return r;
	endfunction

	function automatic logic [9:0] div3_byte(input logic [1:0] r, input logic [7:0] d);
		logic [2:0] t;
		logic [1:0] rr;
		logic [7:0] q;
		rr = r;
		q = '0;
		for (int i = 7; i >= 0; i--) begin
			t = {rr, d[i]};
			if (t >= 3'd3) begin
				q[i] = 1'b1;
				rr = 2'(t - 3'd3);
			end else begin
				rr = t[1:0];
			end
		end
		return {rr, q};
	endfunction

	logic signed [DATA_W-1:0] x_q, v_q, tx_q, kx_q, kv_q;
	logic [CNT_W-1:0]         cnt_q;
	logic signed [MUL_W-1:0]  hi_q, lo_q;
	logic signed [ACC_W-1:0]  sx_q, sv_q;
	logic [DIV_W-1:0]         dx_q, dv_q, qx_q, qv_q;
	logic [1:0]               rx_q, rv_q;
	logic signed [DATA_W-1:0] pos_q, vel_q;
	logic [CNT_W-1:0]         idx_q;

	logic signed [16:0]        m_opb;
	logic signed [MUL_W-1:0]   m_res;
	logic signed [PROD_W-1:0]  prod_full;
	logic signed [DATA_W:0]    p_w;
	logic signed [WIDE_W-1:0]  negp;
	logic signed [DATA_W-1:0]  tx_add, kv_add;
	logic signed [ACC_W-1:0]   sx_add, sv_add;
	logic [ACC_W:0]            ux_w, uv_w;
	logic [9:0]                dstep_x, dstep_v;

	assign m_opb = signed'({1'b0, cmd.mul_hi ? step_gain[GAIN_W-1:16] : step_gain[15:0]});
	assign m_res = MUL_W'(tx_q) * MUL_W'(m_opb);

	assign prod_full = (PROD_W'(hi_q) <<< 16) + PROD_W'(lo_q);
	assign p_w = prod_full[PROD_W-1:32];
	assign negp = -WIDE_W'(p_w);

	assign tx_add = (cmd.stage == ST_K3) ? kx_q : (kx_q >>> 1);
	assign kv_add = (cmd.upd_stage == ST_K3) ? kv_q : (kv_q >>> 1);
	assign sx_add = (cmd.stage == ST_K4) ? ACC_W'(kx_q) : (ACC_W'(kx_q) <<< 1);
	assign sv_add = (cmd.upd_stage == ST_K1 || cmd.upd_stage == ST_K4) ?
		ACC_W'(kv_q) : (ACC_W'(kv_q) <<< 1);

	assign ux_w = (ACC_W + 1)'(sx_q >>> 1) + DIV_BIAS;
	assign uv_w = (ACC_W + 1)'(sv_q >>> 1) + DIV_BIAS;
	assign dstep_x = div3_byte(rx_q, dx_q[DIV_W-1:DIV_W-8]);
	assign dstep_v = div3_byte(rv_q, dv_q[DIV_W-1:DIV_W-8]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q <= DATA_W'(1) << FRAC_BITS;
			v_q <= '0;
			cnt_q <= '0;
		end else if (cmd.restart) begin
			x_q <= start_position;
			v_q <= start_velocity;
			cnt_q <= '0;
		end else if (cmd.start) begin
			cnt_q <= cnt_q + CNT_W'(1);
		end else if (cmd.commit) begin
			x_q <= sat48(WIDE_W'(x_q) + WIDE_W'(qx_q[ACC_W-1:0]) - DIV_OFF);
			v_q <= sat48(WIDE_W'(v_q) + WIDE_W'(qv_q[ACC_W-1:0]) - DIV_OFF);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			pos_q <= x_q;
			vel_q <= v_q;
			idx_q <= cnt_q;
			tx_q <= x_q;
			kx_q <= v_q;
			sx_q <= ACC_W'(v_q);
			sv_q <= '0;
		end
		if (cmd.mul_hi) begin
			hi_q <= m_res;
		end
		if (cmd.mul_lo) begin
			lo_q <= m_res;
		end
		if (cmd.prod) begin
			kv_q <= sat48(negp);
			tx_q <= sat48(WIDE_W'(x_q) + WIDE_W'(tx_add));
			if (cmd.stage != ST_K1) begin
				sx_q <= sx_q + sx_add;
			end
		end
		if (cmd.upd) begin
			kx_q <= sat48(WIDE_W'(v_q) + WIDE_W'(kv_add));
			sv_q <= sv_q + sv_add;
		end
		if (cmd.div_init) begin
			dx_q <= DIV_W'(ux_w[ACC_W-1:0]);
			dv_q <= DIV_W'(uv_w[ACC_W-1:0]);
			qx_q <= '0;
			qv_q <= '0;
			rx_q <= '0;
			rv_q <= '0;
		end else if (cmd.div_step) begin
			dx_q <= dx_q << 8;
			dv_q <= dv_q << 8;
			qx_q <= {qx_q[DIV_W-9:0], dstep_x[7:0]};
			qv_q <= {qv_q[DIV_W-9:0], dstep_v[7:0]};
			rx_q <= dstep_x[9:8];
			rv_q <= dstep_v[9:8];
		end
	end

	assign position = pos_q;
	assign scaled_velocity = vel_q;
	assign step_index = idx_q;

endmodule

// ----- src/rk4_ctrl.sv -----
// Controller: item handshake, result valid flag and the step sequencer.
`include "rk4_harmonic_oscillator_step_defines.svh"
module rk4_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              tick_valid,
	input  logic              restart,
	input  logic              result_stall,
	output logic              tick_stall,
	output logic              result_valid,
	output rk4_pkg::rk4_cmd_t cmd
);
	import rk4_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_HI,
		S_LO,
		S_PROD,
		S_UPD,
		S_DINIT,
		S_DIV,
		S_COMMIT
	} state_t;

	state_t     state_q;
	stage_t     stage_q;
	logic [2:0] dcnt_q;
	logic       result_valid_q;
	logic       accept;
	logic [7:0] dp_ops;
	logic       last_upd;

	assign tick_stall = (state_q != S_IDLE) || (result_valid_q && result_stall);
	assign accept = tick_valid && !tick_stall;
	assign result_valid = result_valid_q;

	assign dp_ops = {cmd.start, cmd.restart, cmd.mul_hi, cmd.mul_lo, cmd.prod, cmd.div_init,
		cmd.div_step, cmd.commit};
	assign last_upd = cmd.upd && (cmd.upd_stage == ST_K4);

	always_comb begin
		cmd = '0;
		cmd.stage = stage_q;
		cmd.upd_stage = stage_q;
		unique case (state_q)
			S_IDLE: begin
				cmd.start = accept && !restart;
				cmd.restart = accept && restart;
			end
			S_HI: begin
				cmd.mul_hi = 1'b1;
				cmd.upd = (stage_q != ST_K1);
				cmd.upd_stage = stage_q - 2'd1;
			end
			S_LO:     cmd.mul_lo = 1'b1;
			S_PROD:   cmd.prod = 1'b1;
			S_UPD:    cmd.upd = 1'b1;
			S_DINIT:  cmd.div_init = 1'b1;
			S_DIV:    cmd.div_step = 1'b1;
			S_COMMIT: cmd.commit = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			stage_q <= ST_K1;
			dcnt_q <= '0;
			result_valid_q <= 1'b0;
		end else begin
			if (cmd.start) begin
				result_valid_q <= 1'b1;
			end else if (result_valid_q && !result_stall) begin
				result_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (cmd.start) begin
						state_q <= S_HI;
						stage_q <= ST_K1;
					end
				end
				S_HI: state_q <= S_LO;
				S_LO: state_q <= S_PROD;
				S_PROD: begin
					if (stage_q == ST_K4) begin
						state_q <= S_UPD;
					end else begin
						stage_q <= stage_q + 2'd1;
						state_q <= S_HI;
					end
				end
				S_UPD: state_q <= S_DINIT;
				S_DINIT: begin
					dcnt_q <= '0;
					state_q <= S_DIV;
				end
				S_DIV: begin
					dcnt_q <= dcnt_q + 3'd1;
					if (dcnt_q == 3'(DIV_STEPS - 1)) begin
						state_q <= S_COMMIT;
					end
				end
				S_COMMIT: state_q <= S_IDLE;
				default:  state_q <= S_IDLE;
			endcase
		end
	end

	`RK4_ASSERT(a_start_enters_k1, clk, arst_n, cmd.start |=> (state_q == S_HI && stage_q == ST_K1))
	`RK4_ASSERT(a_one_dp_op, clk, arst_n, $onehot0(dp_ops))
	`RK4_ASSERT(a_commit_to_idle, clk, arst_n, cmd.commit |=> state_q == S_IDLE)
	`RK4_ASSERT(a_div_after_last_upd, clk, arst_n, cmd.div_init |-> $past(last_upd))
	`RK4_ASSERT_NEVER(a_no_result_overwrite, clk, arst_n, cmd.start && result_valid_q && result_stall)

endmodule

// ----- src/rk4_harmonic_oscillator_step.sv -----
// Fourth-order Runge-Kutta step engine for a linear oscillator, top level.
//
// Input channel tick_valid/tick_stall carries one field, restart. A restart item
// reloads position and scaled velocity from start_position/start_velocity and
// clears the step index; it produces no result. Any other item produces one
// result (position, scaled_velocity, step_index as they stood before the step)
// and then advances the state by one time step.
// The result is registered at the edge that accepts the item and is offered
// on result_valid from the next cycle; it holds while result_stall is high.
// After the accepting edge a step runs four slope evaluations on one shared
// 48x16 gain multiplier (high and low gain halves, then the product combine),
// one last slope update, and a divide by six run as 8 bits per cycle between
// a load step and a commit step.
// No new item is taken until the step is through; tick_stall is high while
// a step runs and while an unread result is stalled.
// Registers sit on an APB-style port at byte addresses 0, 8 and 16 and may be
// written only while the block is idle. Reset restores the register defaults,
// sets the position to one and clears the velocity and the step index.
module rk4_harmonic_oscillator_step #(
	parameter int FRAC_BITS = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              tick_valid,
	output logic                              tick_stall,
	input  logic                              restart,
	output logic                              result_valid,
	input  logic                              result_stall,
	output logic signed [rk4_pkg::DATA_W-1:0] position,
	output logic signed [rk4_pkg::DATA_W-1:0] scaled_velocity,
	output logic [rk4_pkg::CNT_W-1:0]         step_index,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [rk4_pkg::ADDR_W-1:0]        paddr,
	input  logic [rk4_pkg::PDATA_W-1:0]       pwdata,
	output logic [rk4_pkg::PDATA_W-1:0]       prdata,
	output logic                              pready
);
	import rk4_pkg::*;

	rk4_cmd_t                 cmd;
	logic [GAIN_W-1:0]        step_gain;
	logic signed [DATA_W-1:0] start_position;
	logic signed [DATA_W-1:0] start_velocity;

	rk4_regs #(
		.FRAC_BITS(FRAC_BITS)
	) u_regs (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.step_gain     (step_gain),
		.start_position(start_position),
		.start_velocity(start_velocity)
	);

	rk4_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.tick_valid  (tick_valid),
		.restart     (restart),
		.result_stall(result_stall),
		.tick_stall  (tick_stall),
		.result_valid(result_valid),
		.cmd         (cmd)
	);

	rk4_dp #(
		.FRAC_BITS(FRAC_BITS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.step_gain      (step_gain),
		.start_position (start_position),
		.start_velocity (start_velocity),
		.position       (position),
		.scaled_velocity(scaled_velocity),
		.step_index     (step_index)
	);

endmodule

// ----- tb/rk4_harmonic_oscillator_step_checker.sv -----
// Checker that follows the register writes and ticks of the oscillator step block and compares each result.
module rk4_harmonic_oscillator_step_checker #(
	parameter int FRAC_BITS = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              tick_valid,
	input  logic                              tick_stall,
	input  logic                              restart,
	input  logic                              result_valid,
	input  logic                              result_stall,
	input  logic signed [rk4_pkg::DATA_W-1:0] position,
	input  logic signed [rk4_pkg::DATA_W-1:0] scaled_velocity,
	input  logic [rk4_pkg::CNT_W-1:0]         step_index,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [rk4_pkg::ADDR_W-1:0]        paddr,
	input  logic [rk4_pkg::PDATA_W-1:0]       pwdata,
	input  logic                              pready,
	output int                                errors,
	output int                                outstanding,
	output int                                compared
);
	import rk4_pkg::*;

	localparam longint POS_MAX = (longint'(1) <<< (DATA_W - 1)) - 1;
	localparam longint POS_MIN = -POS_MAX - 1;

	typedef struct {
		longint           pos;
		longint           vel;
		logic [CNT_W-1:0] idx;
	} state_sample_t;

	state_sample_t     expected_states[$];
	logic [GAIN_W-1:0] gain;
	longint            init_pos;
	longint            init_vel;
	longint            pos_now;
	longint            vel_now;
	logic [CNT_W-1:0]  steps_done;
	int                mismatches;
	int                n_compared;

	function automatic longint clamp48(input longint a);
		if (a > POS_MAX)
			return POS_MAX;
		if (a < POS_MIN)
			return POS_MIN;
		return a;
	endfunction

	function automatic longint sext48(input logic [PDATA_W-1:0] w);
		logic signed [DATA_W-1:0] t;
		t = w[DATA_W-1:0];
		return longint'(t);
	endfunction

	function automatic longint restoring_slope(input longint y, input logic [GAIN_W-1:0] g);
		logic signed [95:0] wide_y;
		logic signed [95:0] wide_g;
		logic signed [95:0] prod;
		wide_y = y;
		wide_g = {64'd0, g};
		prod = (wide_y * wide_g) >>> GAIN_W;
		return clamp48(-longint'(prod));
	endfunction

	function automatic longint floor_sixth(input longint s);
		longint q;
		q = s / 6;
		if (s % 6 != 0 && s < 0)
			q = q - 1;
		return q;
	endfunction

	function automatic void rk4_advance(input longint x, input longint v,
		input logic [GAIN_W-1:0] g, output longint nx, output longint nv);
		longint k1x, k1v, k2x, k2v, k3x, k3v, k4x, k4v, probe;
		k1x = v;
		k1v = restoring_slope(x, g);
		probe = clamp48(x + (k1x >>> 1));
		k2x = clamp48(v + (k1v >>> 1));
		k2v = restoring_slope(probe, g);
		probe = clamp48(x + (k2x >>> 1));
		k3x = clamp48(v + (k2v >>> 1));
		k3v = restoring_slope(probe, g);
		probe = clamp48(x + k3x);
		k4x = clamp48(v + k3v);
		k4v = restoring_slope(probe, g);
		nx = clamp48(x + floor_sixth(k1x + 2 * k2x + 2 * k3x + k4x));
		nv = clamp48(v + floor_sixth(k1v + 2 * k2v + 2 * k3v + k4v));
	endfunction

	always @(posedge clk or negedge arst_n) begin
		state_sample_t want;
		longint nx;
		longint nv;
		if (!arst_n) begin
			gain = 32'd78496111;
			init_pos = longint'(1) <<< FRAC_BITS;
			init_vel = 0;
			pos_now = longint'(1) <<< FRAC_BITS;
			vel_now = 0;
			steps_done = '0;
			mismatches = 0;
			n_compared = 0;
			expected_states.delete();
			errors <= 0;
			outstanding <= 0;
			compared <= 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (reg_idx_t'(paddr[ADDR_W-1:3]))
					REG_STEP_GAIN: gain = pwdata[GAIN_W-1:0];
					REG_START_POS: init_pos = sext48(pwdata);
					REG_START_VEL: init_vel = sext48(pwdata);
					default: ;
				endcase
			end
			if (tick_valid && !tick_stall) begin
				if (restart) begin
					pos_now = init_pos;
					vel_now = init_vel;
					steps_done = '0;
				end else begin
					want.pos = pos_now;
					want.vel = vel_now;
					want.idx = steps_done;
					expected_states.push_back(want);
					rk4_advance(pos_now, vel_now, gain, nx, nv);
					pos_now = nx;
					vel_now = nv;
					steps_done = steps_done + 1'b1;
				end
			end
			if (result_valid && !result_stall) begin
				if (expected_states.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result: position %0d velocity %0d index %0d",
							position, scaled_velocity, step_index);
				end else begin
					want = expected_states.pop_front();
					n_compared++;
					if (longint'(position) != want.pos || longint'(scaled_velocity) != want.vel
						|| step_index != want.idx) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("mismatch on result %0d:", n_compared);
							$display("  position        expected %0d, got %0d", want.pos, position);
							$display("  scaled_velocity expected %0d, got %0d", want.vel,
								scaled_velocity);
							$display("  step_index      expected %0d, got %0d", want.idx,
								step_index);
						end
					end
				end
			end
			errors <= mismatches;
			outstanding <= expected_states.size();
			compared <= n_compared;
		end
	end

endmodule

// ----- tb/rk4_harmonic_oscillator_step_tb.sv -----
// Top of the oscillator step regression: clock, reset, register setup, tick and stall stimulus, verdict.
module rk4_harmonic_oscillator_step_tb;
	import rk4_pkg::*;

	localparam reg_idx_t REG_SPARE = 2'd3;
	localparam int IDLE_LIMIT = 4000;
	localparam int SETTLE_CYCLES = 30;
	localparam longint POS_MAX = (longint'(1) <<< (DATA_W - 1)) - 1;
	localparam longint POS_MIN = -POS_MAX - 1;

	logic                     clk = 1'b0;
	logic                     arst_n;
	logic                     tick_valid;
	logic                     tick_stall;
	logic                     restart;
	logic                     result_valid;
	logic                     result_stall = 1'b0;
	logic signed [DATA_W-1:0] position;
	logic signed [DATA_W-1:0] scaled_velocity;
	logic [CNT_W-1:0]         step_index;
	logic                     psel;
	logic                     penable;
	logic                     pwrite;
	logic [ADDR_W-1:0]        paddr;
	logic [PDATA_W-1:0]       pwdata;
	logic [PDATA_W-1:0]       prdata;
	logic                     pready;
	int                       errors;
	int                       outstanding;
	int                       compared;

	logic steady = 1'b0;
	int   stall_hold = 0;
	int   quiet_cycles = 0;
	int   items_sent = 0;
	int   restarts_sent = 0;
	int   settings_loaded = 0;

	rk4_harmonic_oscillator_step uut (.*);

	rk4_harmonic_oscillator_step_checker check (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		int pick;
		if (stall_hold > 0) begin
			stall_hold <= stall_hold - 1;
		end else if (steady) begin
			result_stall <= 1'b0;
		end else begin
			pick = $urandom_range(0, 99);
			if (pick < 55) begin
				result_stall <= 1'b0;
				stall_hold <= $urandom_range(0, 5);
			end else if (pick < 92) begin
				result_stall <= 1'b1;
				stall_hold <= $urandom_range(0, 3);
			end else begin
				result_stall <= 1'b1;
				stall_hold <= $urandom_range(10, 80);
			end
		end
	end

	always @(posedge clk) begin
		if ((tick_valid && !tick_stall) || (result_valid && !result_stall) || psel)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= IDLE_LIMIT) begin
			$display("no handshake for %0d cycles", IDLE_LIMIT);
			$display("rk4_harmonic_oscillator_step regression: fail");
			$finish;
		end
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (steady || r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 4);
		return $urandom_range(10, 60);
	endfunction

	function automatic logic [GAIN_W-1:0] pick_gain();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return '0;
		if (r == 1)
			return '1;
		if (r < 6)
			return $urandom;
		return $urandom_range(0, 32'h0800_0000);
	endfunction

	function automatic longint pick_start();
		logic [63:0] t;
		int          r;
		t = {$urandom, $urandom};
		r = $urandom_range(0, 9);
		if (r == 0)
			return POS_MAX;
		if (r == 1)
			return POS_MIN;
		if (r == 2)
			return 0;
		if (r < 6)
			return longint'($signed(t[DATA_W-1:0]));
		return longint'($signed(t[36:0]));
	endfunction

	task automatic apb_write(input reg_idx_t idx, input logic [PDATA_W-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 3'b000};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic configure(input logic [GAIN_W-1:0] gain, input longint pos,
		input longint vel);
		apb_write(REG_STEP_GAIN, {$urandom, gain});
		apb_write(REG_START_POS, {16'($urandom), pos[DATA_W-1:0]});
		apb_write(REG_START_VEL, {16'($urandom), vel[DATA_W-1:0]});
		settings_loaded++;
	endtask

	task automatic send_tick(input logic reload);
		int gap;
		tick_valid <= 1'b1;
		restart <= reload;
		do @(posedge clk); while (tick_stall);
		items_sent++;
		if (reload)
			restarts_sent++;
		gap = pick_gap();
		if (gap > 0) begin
			tick_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drain();
		tick_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		arst_n <= 1'b0;
		tick_valid <= 1'b0;
		restart <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Steps from the reset state, then a reload of the default start registers.
		repeat (3) send_tick(1'b0);
		send_tick(1'b1);
		send_tick(1'b0);
		drain();
		configure('1, POS_MAX, POS_MAX);
		send_tick(1'b1);
		repeat (3) send_tick(1'b0);
		drain();
		configure('1, POS_MIN, POS_MIN);
		send_tick(1'b1);
		repeat (3) send_tick(1'b0);
		drain();
		configure('0, POS_MIN, POS_MAX);
		// A write to an address with no register behind it must change nothing.
		apb_write(REG_SPARE, {$urandom, $urandom});
		send_tick(1'b1);
		repeat (2) send_tick(1'b0);
		drain();
		configure(32'd1, -1, 1);
		send_tick(1'b1);
		send_tick(1'b1);
		repeat (2) send_tick(1'b0);

		for (int phase = 0; phase < 8; phase++) begin
			drain();
			configure(pick_gain(), pick_start(), pick_start());
			steady = (phase % 4 == 3);
			send_tick(1'b1);
			for (int i = 0; i < 240; i++) begin
				if (i == 120)
					drain();
				send_tick($urandom_range(0, 19) == 0);
			end
		end
		steady = 1'b0;

		drain();
		$display("Covered %0d ticks (%0d reloads) under %0d register settings;",
			items_sent, restarts_sent, settings_loaded);
		$display("%0d results compared, %0d mismatches.", compared, errors);
		if (errors == 0 && outstanding == 0)
			$display("rk4_harmonic_oscillator_step regression: pass");
		else
			$display("rk4_harmonic_oscillator_step regression: fail");
		$finish;
	end

endmodule
